// ===== src/prp_pkg.sv =====
// Shared types and constants for the point rotate and project block.
// Used by prp_coef and point_rotate_project_unit; depends on nothing else.
package prp_pkg;

  // Trig and coefficient format: Q.30 values held in 34-bit signed words.
  localparam int TRIG_W       = 34;
  localparam int TRIG_ONE     = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 3'd6;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [7:0]         star_size;
    logic               frame_end;
  } point_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               frame_end_out;
  } screen_t;

  // The two projected rows of the combined rotation matrix.
  typedef struct packed {
    logic signed [TRIG_W-1:0] a0;
    logic signed [TRIG_W-1:0] a1;
    logic signed [TRIG_W-1:0] a2;
    logic signed [TRIG_W-1:0] b0;
    logic signed [TRIG_W-1:0] b1;
    logic signed [TRIG_W-1:0] b2;
  } coef_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [TRIG_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic signed [TRIG_W-1:0] r;
    unique case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/prp_coef.sv =====
// Rotation coefficient unit: CORDIC sine and cosine of the three angles and
// the six matrix coefficients, formed with one shared multiplier. Uses prp_pkg.
module prp_coef (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [15:0]  angle_x,
  input  logic signed [15:0]  angle_y,
  input  logic signed [15:0]  angle_z,
  output logic                busy,
  output prp_pkg::coef_t      coef
);
  import prp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_ROT  = 4'b0100,
    ST_MUL  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    M_SXSY, M_SZSX, M_SXCY, M_A0, M_A0S, M_A1, M_A2,
    M_A2S, M_B0, M_B0S, M_B1, M_B2, M_B2S, M_END
  } mop_t;

  localparam logic signed [TRIG_W-1:0] QUARTER = 34'sd1 << 30;
  localparam logic signed [TRIG_W-1:0] HALF    = 34'sd1 << 31;
  localparam logic signed [2*TRIG_W-1:0] ROUND_HALF = 68'sd1 <<< (TRIG_ONE - 1);

  state_t                   state;
  logic [1:0]               sel;
  logic [STEP_W-1:0]        step;
  logic                     flip;
  logic signed [TRIG_W-1:0] x, y, z;
  logic signed [TRIG_W-1:0] cx, sx, cy, sy, cz, sz;
  logic signed [TRIG_W-1:0] t_sxsy, t_szsx, t_sxcy;
  mop_t                     mop, ptag;
  logic                     pv;
  logic signed [2*TRIG_W-1:0] prod;

  logic signed [15:0]       ang;
  logic signed [TRIG_W-1:0] z0, z_fold, xs, ys, x_n, y_n, z_n;
  logic                     fold;
  logic signed [TRIG_W-1:0] opa, opb, rnd;
  logic signed [2*TRIG_W-1:0] prod_r;

  always_comb begin
    unique case (sel)
      2'd0:    ang = angle_x;
      2'd1:    ang = angle_y;
      default: ang = angle_z;
    endcase
    z0 = {{2{ang[15]}}, ang, 16'b0};
    fold = 1'b0;
    z_fold = z0;
    if (z0 > QUARTER) begin
      z_fold = z0 - HALF;
      fold = 1'b1;
    end else if (z0 < -QUARTER) begin
      z_fold = z0 + HALF;
      fold = 1'b1;
    end
    xs = x >>> step;
    ys = y >>> step;
    if (!z[TRIG_W-1]) begin
      x_n = x - ys;
      y_n = y + xs;
      z_n = z - atan_turn(step);
    end else begin
      x_n = x + ys;
      y_n = y - xs;
      z_n = z + atan_turn(step);
    end
  end

  always_comb begin
    unique case (mop)
      M_SXSY:  begin opa = sx;     opb = sy; end
      M_SZSX:  begin opa = sz;     opb = sx; end
      M_SXCY:  begin opa = sx;     opb = cy; end
      M_A0:    begin opa = cy;     opb = cz; end
      M_A0S:   begin opa = t_sxsy; opb = sz; end
      M_A1:    begin opa = cx;     opb = sz; end
      M_A2:    begin opa = sy;     opb = cz; end
      M_A2S:   begin opa = t_szsx; opb = cy; end
      M_B0:    begin opa = cy;     opb = sz; end
      M_B0S:   begin opa = t_sxsy; opb = cz; end
      M_B1:    begin opa = cx;     opb = cz; end
      M_B2:    begin opa = sy;     opb = sz; end
      M_B2S:   begin opa = t_sxcy; opb = cz; end
      default: begin opa = '0;     opb = '0; end
    endcase
    prod_r = (prod + ROUND_HALF) >>> TRIG_ONE;
    rnd = prod_r[TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      state <= ST_LOAD;
      sel   <= 2'd0;
      step  <= '0;
      pv    <= 1'b0;
      mop   <= M_SXSY;
    end else begin
      unique case (state)
        ST_LOAD: begin
          x     <= CORDIC_GAIN;
          y     <= '0;
          z     <= z_fold;
          flip  <= fold;
          step  <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          x    <= x_n;
          y    <= y_n;
          z    <= z_n;
          step <= step + 1'b1;
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            unique case (sel)
              2'd0: begin
                cx <= flip ? -x_n : x_n;
                sx <= flip ? -y_n : y_n;
              end
              2'd1: begin
                cy <= flip ? -x_n : x_n;
                sy <= flip ? -y_n : y_n;
              end
              default: begin
                cz <= flip ? -x_n : x_n;
                sz <= flip ? -y_n : y_n;
              end
            endcase
            if (sel == 2'd2) begin
              state <= ST_MUL;
              mop   <= M_SXSY;
            end else begin
              sel   <= sel + 2'd1;
              state <= ST_LOAD;
            end
          end
        end
        ST_MUL: begin
          if (mop != M_END) begin
            prod <= opa * opb;
            ptag <= mop;
            pv   <= 1'b1;
            mop  <= mop_t'(mop + 4'd1);
          end else begin
            pv    <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Write side of the multiplier: rounded product goes to its destination.
  always_ff @(posedge clk) begin
    if (pv) begin
      unique case (ptag)
        M_SXSY:  t_sxsy  <= rnd;
        M_SZSX:  t_szsx  <= rnd;
        M_SXCY:  t_sxcy  <= rnd;
        M_A0:    coef.a0 <= rnd;
        M_A0S:   coef.a0 <= coef.a0 - rnd;
        M_A1:    coef.a1 <= -rnd;
        M_A2:    coef.a2 <= rnd;
        M_A2S:   coef.a2 <= coef.a2 + rnd;
        M_B0:    coef.b0 <= rnd;
        M_B0S:   coef.b0 <= coef.b0 + rnd;
        M_B1:    coef.b1 <= rnd;
        M_B2:    coef.b2 <= rnd;
        M_B2S:   coef.b2 <= coef.b2 - rnd;
        default: ;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== src/point_rotate_project_unit.sv =====
// Point rotate and project unit: four-stage pipeline, one word per cycle while
// neither screen stall nor the coefficient unit holds the flow back.
// After reset, and after any angle register write, the coefficient unit runs
// three CORDIC passes and then its multiply sequence with point stall held
// high. Reset is synchronous and clears the valid bits and the configuration
// registers; datapath registers are not cleared.
module point_rotate_project_unit #(
  parameter int UNIT_FRAC_BITS = 14,
  parameter int SCREEN_BITS    = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             point_valid,
  output logic                             point_stall,
  input  prp_pkg::point_t                  point,
  output logic                             screen_valid,
  input  logic                             screen_stall,
  output prp_pkg::screen_t                 screen,
  input  logic                             cfg_write,
  input  logic [prp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import prp_pkg::*;

  // Width plan. A coefficient times a 16-bit coordinate, three summed, then
  // rounded down by the point's fraction bits to a Q.30 row value.
  localparam int MP_W   = TRIG_W + 16;
  localparam int SUM_W  = MP_W + 3;
  localparam int ROW_W  = SUM_W - UNIT_FRAC_BITS;
  localparam int PROD_W = ROW_W + SCREEN_BITS + 1;
  localparam int PIX_W  = PROD_W + 1 - TRIG_ONE;
  localparam int V_W    = PIX_W + SCREEN_BITS + 18;

  localparam logic signed [SUM_W-1:0]  ROW_HALF = SUM_W'(1) <<< (UNIT_FRAC_BITS - 1);
  localparam logic signed [PROD_W:0]   PIX_HALF = (PROD_W + 1)'(1) <<< (TRIG_ONE - 1);
  localparam logic signed [V_W-1:0]    SAT_HI   = V_W'(32767);
  localparam logic signed [V_W-1:0]    SAT_LO   = -V_W'(32768);

  // Configuration registers.
  logic signed [15:0]       angle_x, angle_y, angle_z;
  logic [SCREEN_BITS-1:0]   center_x, center_y, half_width, half_height;
  logic                     angle_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x     <= '0;
      angle_y     <= '0;
      angle_z     <= '0;
      center_x    <= '0;
      center_y    <= '0;
      half_width  <= '0;
      half_height <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ANGLE_X:     angle_x     <= cfg_data;
        REG_ANGLE_Y:     angle_y     <= cfg_data;
        REG_ANGLE_Z:     angle_z     <= cfg_data;
        REG_CENTER_X:    center_x    <= cfg_data[SCREEN_BITS-1:0];
        REG_CENTER_Y:    center_y    <= cfg_data[SCREEN_BITS-1:0];
        REG_HALF_WIDTH:  half_width  <= cfg_data[SCREEN_BITS-1:0];
        REG_HALF_HEIGHT: half_height <= cfg_data[SCREEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Any angle write invalidates the matrix and restarts the coefficient unit.
  assign angle_write = cfg_write &&
    (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y || cfg_index == REG_ANGLE_Z);

  logic  busy;
  coef_t coef;

  prp_coef u_coef (
    .clk     (clk),
    .rst     (rst),
    .start   (angle_write),
    .angle_x (angle_x),
    .angle_y (angle_y),
    .angle_z (angle_z),
    .busy    (busy),
    .coef    (coef)
  );

  // Pipeline control. Each stage loads when it is empty or its contents move
  // on, so a bubble anywhere is squeezed out and input keeps flowing while a
  // finished word waits in the output register, until the stages behind it fill.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic point_accept;

  assign en4 = !v4 || !screen_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign point_stall  = busy || !en1;
  assign point_accept = point_valid && !point_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= point_accept;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: six coefficient-by-coordinate products.
  logic signed [MP_W-1:0] ax, ay, az, bx, by, bz;
  logic [7:0]             size1, size2, size3;
  logic                   fe1, fe2, fe3;

  always_ff @(posedge clk) begin
    if (en1 && point_accept) begin
      ax    <= coef.a0 * point.point_x;
      ay    <= coef.a1 * point.point_y;
      az    <= coef.a2 * point.point_z;
      bx    <= coef.b0 * point.point_x;
      by    <= coef.b1 * point.point_y;
      bz    <= coef.b2 * point.point_z;
      size1 <= point.star_size;
      fe1   <= point.frame_end;
    end
  end

  // Stage 2: row sums, rounded half up to Q.30.
  logic signed [SUM_W-1:0] sum_x, sum_y, shr_x, shr_y;
  logic signed [ROW_W-1:0] row_x, row_y;

  always_comb begin
    sum_x = SUM_W'(ax) + SUM_W'(ay) + SUM_W'(az) + ROW_HALF;
    sum_y = SUM_W'(bx) + SUM_W'(by) + SUM_W'(bz) + ROW_HALF;
    shr_x = sum_x >>> UNIT_FRAC_BITS;
    shr_y = sum_y >>> UNIT_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      row_x <= shr_x[ROW_W-1:0];
      row_y <= shr_y[ROW_W-1:0];
      size2 <= size1;
      fe2   <= fe1;
    end
  end

  // Stage 3: scale by the half width and half height.
  logic signed [PROD_W-1:0] scl_x, scl_y;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      scl_x <= row_x * $signed({1'b0, half_width});
      scl_y <= row_y * $signed({1'b0, half_height});
      size3 <= size2;
      fe3   <= fe2;
    end
  end

  // Stage 4: round to pixels, move to the centre, take off the star size and
  // saturate to 16 bits.
  logic signed [PROD_W:0]  pix_x, pix_y;
  logic signed [V_W-1:0]   pos_x, pos_y, sat_x, sat_y;

  always_comb begin
    pix_x = ((PROD_W + 1)'(scl_x) + PIX_HALF) >>> TRIG_ONE;
    pix_y = ((PROD_W + 1)'(scl_y) + PIX_HALF) >>> TRIG_ONE;
    pos_x = V_W'(pix_x) + V_W'({1'b0, center_x}) - V_W'({1'b0, size3});
    pos_y = V_W'(pix_y) + V_W'({1'b0, center_y}) - V_W'({1'b0, size3});
    priority if (pos_x > SAT_HI) sat_x = SAT_HI;
    else if (pos_x < SAT_LO)     sat_x = SAT_LO;
    else                         sat_x = pos_x;
    priority if (pos_y > SAT_HI) sat_y = SAT_HI;
    else if (pos_y < SAT_LO)     sat_y = SAT_LO;
    else                         sat_y = pos_y;
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      screen.screen_x      <= sat_x[15:0];
      screen.screen_y      <= sat_y[15:0];
      screen.frame_end_out <= fe3;
    end
  end

  assign screen_valid = v4;

`ifndef SYNTHESIS
  // An angle write always starts a new coefficient pass.
  a_angle_busy: assert property (@(posedge clk) disable iff (rst)
    angle_write |=> busy)
    else $error("angle write did not start coefficient unit");

  // Stage 1, holding a word that cannot move on, keeps it.
  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !en2) |=> v1)
    else $error("stage 1 word lost under stall");

  // No point word enters while the coefficients are being rebuilt.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> !(v1 && $past(en1)))
    else $error("point accepted while coefficients busy");
`endif

endmodule
